// ----- rtl/core/jhmp_pkg.sv -----
// shared types and constants for the jpeg header marker parser
package jhmp_pkg;

  localparam int MAX_COMPONENTS_DEF = 4;

  localparam logic [2:0] KIND_FRAME = 3'd0;
  localparam logic [2:0] KIND_COMP  = 3'd1;
  localparam logic [2:0] KIND_QUANT = 3'd2;
  localparam logic [2:0] KIND_HCNT  = 3'd3;
  localparam logic [2:0] KIND_HSYM  = 3'd4;
  localparam logic [2:0] KIND_SCAN  = 3'd5;
  localparam logic [2:0] KIND_DONE  = 3'd6;
  localparam logic [2:0] KIND_ERROR = 3'd7;

  localparam logic [1:0] ERR_JFIF = 2'd0;
  localparam logic [1:0] ERR_PREC = 2'd1;
  localparam logic [1:0] ERR_DHT  = 2'd2;
  localparam logic [1:0] ERR_SOS  = 2'd3;

  localparam logic [7:0] MARK_SOI  = 8'd216;
  localparam logic [7:0] MARK_APP0 = 8'd224;
  localparam logic [7:0] MARK_DQT  = 8'd219;
  localparam logic [7:0] MARK_SOF0 = 8'd192;
  localparam logic [7:0] MARK_DHT  = 8'd196;
  localparam logic [7:0] MARK_SOS  = 8'd218;
  localparam logic [7:0] MARK_FF   = 8'd255;

  typedef struct packed {
    logic [7:0] byte_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  table_index;
    logic        table_class;
    logic [11:0] position;
    logic [7:0]  entry_value;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [3:0]  horiz_factor;
    logic [3:0]  vert_factor;
    logic [3:0]  dc_select;
    logic [3:0]  ac_select;
    logic [1:0]  error_code;
  } out_word_t;

  function automatic logic [7:0] jfif_tag(input logic [2:0] i);
    case (i)
      3'd0: jfif_tag = 8'd74;
      3'd1: jfif_tag = 8'd70;
      3'd2: jfif_tag = 8'd73;
      3'd3: jfif_tag = 8'd70;
      3'd4: jfif_tag = 8'd0;
      default: jfif_tag = 8'd1;
    endcase
  endfunction

endpackage

// ----- rtl/core/jhmp_stream_if.sv -----
// valid/ready channel carrying one payload word
interface jhmp_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/jpeg_header_marker_parser_core.sv -----
// jpeg header marker parser: one file byte per word in, at most one result word out
// result: registered, shown at the output in the cycle after its byte is accepted
// throughput: one byte per cycle; the only stall is a held output register
// the parse state machine and the output valid flag are cleared by synchronous rst
// after reset the component id store is undefined until a start-of-frame writes it
// after done or error every byte is consumed with no result until reset
module jpeg_header_marker_parser_core #(
  parameter int MAX_COMPONENTS = jhmp_pkg::MAX_COMPONENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  jhmp_stream_if.sink   in_s,
  jhmp_stream_if.source out_s
);
  import jhmp_pkg::*;

  localparam int SW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  typedef enum logic [3:0] {
    PH_FIRST, PH_SOI, PH_HUNT, PH_MARK, PH_APP0, PH_DQT, PH_SOF, PH_SOFC,
    PH_DHT, PH_DHTS, PH_SOS, PH_SOSC, PH_SOST, PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [11:0] cnt, cnt_next;
  logic [11:0] syms, syms_next;
  logic [3:0]  tidx, tidx_next;
  logic        tcls, tcls_next;
  logic [7:0]  comps, comps_next;
  logic [15:0] hgt, hgt_next;
  logic [15:0] wid, wid_next;
  logic [7:0]  pid, pid_next;
  logic [7:0]  psamp, psamp_next;
  logic [7:0]  total, total_next;
  logic [7:0]  slot, slot_next;
  logic [7:0]  ids [MAX_COMPONENTS];
  logic        id_we;

  logic        ovalid;
  out_word_t   odata;
  logic        res_v;
  out_word_t   res;
  logic        take;
  logic [7:0]  b;
  logic        hit;
  logic [SW-1:0] hit_slot;

  assign in_s.ready  = !ovalid || out_s.ready;
  assign take        = in_s.valid && in_s.ready;
  assign out_s.valid = ovalid;
  assign out_s.data  = odata;
  assign b           = in_s.data.byte_in;

  // first stored slot whose id matches, priority to the lowest
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    for (int j = MAX_COMPONENTS - 1; j >= 0; j--) begin
      if (8'(j) < total && ids[j] == pid) begin
        hit = 1'b1;
        hit_slot = SW'(j);
      end
    end
  end

  always_comb begin
    phase_next = phase; cnt_next = cnt; syms_next = syms; tidx_next = tidx;
    tcls_next = tcls; comps_next = comps; hgt_next = hgt; wid_next = wid;
    pid_next = pid; psamp_next = psamp; total_next = total; slot_next = slot;
    id_we = 1'b0;
    res_v = 1'b0;
    res = '0;
    case (phase)
      PH_FIRST: phase_next = PH_SOI;
      PH_SOI: begin
        if (b == MARK_SOI) begin
          phase_next = PH_HUNT;
        end else begin
          res_v = 1'b1; res.kind = KIND_DONE; phase_next = PH_HALT;
        end
      end
      PH_HUNT: if (b == MARK_FF) phase_next = PH_MARK;
      PH_MARK: begin
        cnt_next = '0;
        case (b)
          MARK_APP0: phase_next = PH_APP0;
          MARK_DQT:  phase_next = PH_DQT;
          MARK_SOF0: phase_next = PH_SOF;
          MARK_DHT:  phase_next = PH_DHT;
          MARK_SOS:  phase_next = PH_SOS;
          default:   phase_next = PH_HUNT;
        endcase
      end
      PH_APP0: begin
        if (cnt >= 12'd2 && cnt <= 12'd8 && b != jfif_tag(3'(cnt - 12'd2))) begin
          res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_JFIF;
          phase_next = PH_HALT;
        end else begin
          if (cnt >= 12'd8) phase_next = PH_HUNT;
          cnt_next = cnt + 12'd1;
        end
      end
      PH_DQT: begin
        cnt_next = cnt + 12'd1;
        if (cnt == 12'd2) begin
          tidx_next = b[3:0];
        end else if (cnt > 12'd2) begin
          res_v = 1'b1; res.kind = KIND_QUANT; res.table_index = tidx;
          res.position = cnt - 12'd3; res.entry_value = b;
          if (cnt >= 12'd66) phase_next = PH_HUNT;
        end
      end
      PH_SOF: begin
        cnt_next = cnt + 12'd1;
        if (cnt == 12'd2 && b != 8'd8) begin
          res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_PREC;
          phase_next = PH_HALT;
        end else if (cnt == 12'd3) begin
          hgt_next = {b, 8'd0};
        end else if (cnt == 12'd4) begin
          hgt_next = {hgt[15:8], b};
        end else if (cnt == 12'd5) begin
          wid_next = {b, 8'd0};
        end else if (cnt == 12'd6) begin
          wid_next = {wid[15:8], b};
          res_v = 1'b1; res.kind = KIND_FRAME;
          res.frame_height = hgt; res.frame_width = {wid[15:8], b};
        end else if (cnt >= 12'd7) begin
          comps_next = b; total_next = '0; slot_next = '0; cnt_next = '0;
          phase_next = (b == 8'd0) ? PH_HUNT : PH_SOFC;
        end
      end
      PH_SOFC: begin
        if (cnt == 12'd0) begin
          pid_next = b; cnt_next = 12'd1;
        end else if (cnt == 12'd1) begin
          psamp_next = b; cnt_next = 12'd2;
        end else begin
          res_v = 1'b1; res.kind = KIND_COMP; res.table_index = slot[3:0];
          res.position = {4'd0, pid}; res.entry_value = b;
          res.horiz_factor = psamp[7:4]; res.vert_factor = psamp[3:0];
          if (32'(slot) < MAX_COMPONENTS) begin
            id_we = 1'b1; total_next = slot + 8'd1;
          end
          slot_next = slot + 8'd1;
          comps_next = comps - 8'd1;
          cnt_next = '0;
          if (comps == 8'd1) phase_next = PH_HUNT;
        end
      end
      PH_DHT: begin
        cnt_next = cnt + 12'd1;
        if (cnt == 12'd2) begin
          if (b[7:5] != 3'd0) begin
            res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_DHT;
            phase_next = PH_HALT;
          end else begin
            tcls_next = b[4]; tidx_next = b[3:0]; syms_next = '0;
          end
        end else if (cnt > 12'd2) begin
          res_v = 1'b1; res.kind = KIND_HCNT; res.table_index = tidx;
          res.table_class = tcls; res.position = cnt - 12'd3; res.entry_value = b;
          syms_next = syms + {4'd0, b};
          if (cnt >= 12'd18) begin
            cnt_next = '0;
            phase_next = (syms_next == 12'd0) ? PH_HUNT : PH_DHTS;
          end
        end
      end
      PH_DHTS: begin
        res_v = 1'b1; res.kind = KIND_HSYM; res.table_index = tidx;
        res.table_class = tcls; res.position = cnt; res.entry_value = b;
        cnt_next = cnt + 12'd1;
        syms_next = syms - 12'd1;
        if (syms == 12'd1) phase_next = PH_HUNT;
      end
      PH_SOS: begin
        cnt_next = cnt + 12'd1;
        if (cnt >= 12'd2) begin
          comps_next = b; cnt_next = '0;
          phase_next = (b == 8'd0) ? PH_SOST : PH_SOSC;
        end
      end
      PH_SOSC: begin
        if (cnt == 12'd0) begin
          pid_next = b; cnt_next = 12'd1;
        end else begin
          cnt_next = '0;
          comps_next = comps - 8'd1;
          if (comps == 8'd1) phase_next = PH_SOST;
          if (hit) begin
            res_v = 1'b1; res.kind = KIND_SCAN;
            res.table_index = 4'(hit_slot); res.position = {4'd0, pid};
            res.dc_select = b[7:4]; res.ac_select = b[3:0];
          end
        end
      end
      PH_SOST: begin
        if ((cnt == 12'd1) ? (b != 8'd63) : (b != 8'd0)) begin
          res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_SOS;
          phase_next = PH_HALT;
        end else begin
          cnt_next = cnt + 12'd1;
          if (cnt >= 12'd2) begin
            res_v = 1'b1; res.kind = KIND_DONE; phase_next = PH_HALT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST; cnt <= '0; syms <= '0; tidx <= '0; tcls <= 1'b0;
      comps <= '0; hgt <= '0; wid <= '0; pid <= '0; psamp <= '0;
      total <= '0; slot <= '0; ovalid <= 1'b0;
    end else begin
      if (out_s.ready) ovalid <= 1'b0;
      if (take) begin
        phase <= phase_next; cnt <= cnt_next; syms <= syms_next;
        tidx <= tidx_next; tcls <= tcls_next; comps <= comps_next;
        hgt <= hgt_next; wid <= wid_next; pid <= pid_next;
        psamp <= psamp_next; total <= total_next; slot <= slot_next;
        if (res_v) ovalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_v) odata <= res;
    if (take && id_we) ids[SW'(slot)] <= pid;
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !out_s.ready |=> ovalid && $stable(odata))
    else $error("result word changed while stalled");
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |-> !res_v)
    else $error("result after done or error");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("left halt without reset");
  a_total: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= MAX_COMPONENTS)
    else $error("stored id count beyond store depth");
`endif

endmodule
